// File: hw/rtl/i2cmb_pkg.sv
// Shared types and constants for the I2C master byte controller.
// No dependencies; imported by every module of the block.
package i2cmb_pkg;

   localparam int unsigned DIVIDER_BITS = 16;
   localparam int unsigned QUEUE_DEPTH  = 4;
   localparam int unsigned QUEUE_AW     = $clog2(QUEUE_DEPTH);
   localparam int unsigned REQ_BYTES    = 2;
   localparam int unsigned RSP_BYTES    = 2;

   localparam logic [DIVIDER_BITS-1:0] HALF_PERIOD_RESET = DIVIDER_BITS'(250);
   localparam logic [7:0] BYTE_ALL_ONES  = 8'hFF;
   localparam logic [3:0] BIT_COUNT_LOAD = 4'h8;
   localparam logic [3:0] BIT_COUNT_ACK  = 4'hF;
   localparam logic [3:0] BIT_COUNT_ZERO = 4'h0;

   typedef enum logic [2:0] {
      CMD_NONE  = 3'd0,
      CMD_START = 3'd1,
      CMD_STOP  = 3'd2,
      CMD_WRITE = 3'd3,
      CMD_READ  = 3'd4
   } cmd_code_type;

   typedef enum logic [4:0] {
      KIND_NONE  = 5'b00001,
      KIND_START = 5'b00010,
      KIND_STOP  = 5'b00100,
      KIND_WRITE = 5'b01000,
      KIND_READ  = 5'b10000
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] tx_byte;
      logic       send_ack;
      logic       sda_in;
   } queue_item_type;

   typedef struct packed {
      logic                scl_out;
      logic                sda_out;
      logic                busy_res;
      logic                done_res;
      logic [7:0]          rx_byte;
      logic                ack_seen;
   } result_type;

   typedef struct packed {
      logic                valid;
      logic                full;
      logic [QUEUE_AW:0]   count;
   } queue_status_type;

endpackage

// File: hw/rtl/i2cmb_front.sv
// Front end: registers incoming ticks and classifies the command code.
// Depends on i2cmb_pkg; feeds i2cmb_queue.
module i2cmb_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [2:0]               req_cmd,
   input  logic [7:0]               req_tx_byte,
   input  logic                     req_send_ack,
   input  logic                     req_sda_in,
   output logic                     push_valid,
   input  logic                     push_ready,
   output i2cmb_pkg::queue_item_type push_item
);
   import i2cmb_pkg::*;

   logic           valid_ff, valid_in;
   queue_item_type item_ff, item_in;
   kind_type       kind;

   always_comb begin
      unique case (req_cmd)
         CMD_START: kind = KIND_START;
         CMD_STOP:  kind = KIND_STOP;
         CMD_WRITE: kind = KIND_WRITE;
         CMD_READ:  kind = KIND_READ;
         default:   kind = KIND_NONE;
      endcase
   end

   assign req_tready = !valid_ff || push_ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (req_tvalid && req_tready) begin
         valid_in         = 1'b1;
         item_in.kind     = kind;
         item_in.tx_byte  = req_tx_byte;
         item_in.send_ack = req_send_ack;
         item_in.sda_in   = req_sda_in;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign push_valid = valid_ff;
   assign push_item  = item_ff;

endmodule

// File: hw/rtl/i2cmb_queue.sv
// Short queue of classified ticks between front end and bus engine.
// Depends on i2cmb_pkg.
module i2cmb_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  i2cmb_pkg::queue_item_type   in_item,
   output logic                        out_valid,
   input  logic                        out_ready,
   output i2cmb_pkg::queue_item_type   out_item,
   output i2cmb_pkg::queue_status_type status
);
   import i2cmb_pkg::*;

   queue_item_type      slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]   count_ff, count_in;
   logic                full, push, pop;

   assign full      = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign in_ready  = !full;
   assign out_valid = (count_ff != '0);
   assign out_item  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && !full;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_item;
      end
   end

   assign status.valid = out_valid;
   assign status.full  = full;
   assign status.count = count_ff;

endmodule

// File: hw/rtl/i2cmb_engine.sv
// Bus engine: half-period divider, bit sequencer and result register.
// Depends on i2cmb_pkg; drains i2cmb_queue.
module i2cmb_engine (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   input  logic [i2cmb_pkg::DIVIDER_BITS-1:0]  csr_data,
   input  logic                                pop_valid,
   output logic                                pop_ready,
   input  i2cmb_pkg::queue_item_type           pop_item,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output i2cmb_pkg::result_type               rsp_result
);
   import i2cmb_pkg::*;

   typedef enum logic [14:0] {
      PH_IDLE  = 15'b000000000000001,
      PH_ST0   = 15'b000000000000010,
      PH_ST1   = 15'b000000000000100,
      PH_ST2   = 15'b000000000001000,
      PH_SP0   = 15'b000000000010000,
      PH_SP1   = 15'b000000000100000,
      PH_SP2   = 15'b000000001000000,
      PH_W_LO  = 15'b000000010000000,
      PH_W_HI  = 15'b000000100000000,
      PH_WA_LO = 15'b000001000000000,
      PH_WA_HI = 15'b000010000000000,
      PH_R_LO  = 15'b000100000000000,
      PH_R_HI  = 15'b001000000000000,
      PH_RA_LO = 15'b010000000000000,
      PH_RA_HI = 15'b100000000000000
   } phase_type;

   phase_type               phase_ff, phase_in;
   logic [3:0]              bit_count_ff, bit_count_in;
   logic [7:0]              shift_reg_ff, shift_reg_in;
   logic [DIVIDER_BITS-1:0] divider_ff, divider_in;
   logic [DIVIDER_BITS-1:0] half_period_ff;
   logic                    scl_ff, scl_in;
   logic                    sda_ff, sda_in;
   logic                    ack_choice_ff, ack_choice_in;
   logic                    ack_flag_ff, ack_flag_in;
   logic [7:0]              rx_hold_ff, rx_hold_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   result_type              result_ff, result_in;
   logic                    done;
   logic                    step;
   logic [DIVIDER_BITS:0]   limit;
   logic [DIVIDER_BITS:0]   div_next;

   assign pop_ready = !rsp_valid_ff || rsp_ready;
   assign step      = pop_valid && pop_ready;
   assign limit     = (half_period_ff == '0) ? (DIVIDER_BITS+1)'(1)
                                             : {1'b0, half_period_ff};
   assign div_next  = {1'b0, divider_ff} + (DIVIDER_BITS+1)'(1);

   always_comb begin
      phase_in      = phase_ff;
      bit_count_in  = bit_count_ff;
      shift_reg_in  = shift_reg_ff;
      divider_in    = divider_ff;
      scl_in        = scl_ff;
      sda_in        = sda_ff;
      ack_choice_in = ack_choice_ff;
      ack_flag_in   = ack_flag_ff;
      rx_hold_in    = rx_hold_ff;
      done          = 1'b0;
      if (phase_ff == PH_IDLE) begin
         divider_in = '0;
         unique case (pop_item.kind)
            KIND_START: begin
               phase_in = PH_ST0;
               scl_in   = 1'b1;
            end
            KIND_STOP: begin
               phase_in = PH_SP0;
               sda_in   = 1'b0;
            end
            KIND_WRITE: begin
               phase_in     = PH_W_LO;
               shift_reg_in = pop_item.tx_byte;
               bit_count_in = BIT_COUNT_LOAD;
               scl_in       = 1'b0;
               sda_in       = pop_item.tx_byte[7];
            end
            KIND_READ: begin
               phase_in      = PH_R_LO;
               shift_reg_in  = BYTE_ALL_ONES;
               bit_count_in  = BIT_COUNT_LOAD;
               scl_in        = 1'b0;
               sda_in        = 1'b1;
               ack_choice_in = pop_item.send_ack;
            end
            default: begin
            end
         endcase
      end else if (div_next < limit) begin
         divider_in = div_next[DIVIDER_BITS-1:0];
      end else begin
         divider_in = '0;
         unique case (phase_ff)
            PH_ST0: begin
               phase_in = PH_ST1;
               sda_in   = 1'b0;
            end
            PH_ST1: begin
               phase_in = PH_ST2;
               scl_in   = 1'b0;
            end
            PH_ST2: begin
               phase_in     = PH_IDLE;
               sda_in       = 1'b1;
               shift_reg_in = BYTE_ALL_ONES;
               done         = 1'b1;
            end
            PH_SP0: begin
               phase_in = PH_SP1;
               scl_in   = 1'b1;
            end
            PH_SP1: begin
               phase_in = PH_SP2;
               sda_in   = 1'b1;
            end
            PH_SP2: begin
               phase_in = PH_IDLE;
               done     = 1'b1;
            end
            PH_W_LO, PH_R_LO, PH_RA_LO, PH_WA_LO: begin
               unique case (phase_ff)
                  PH_W_LO:  phase_in = PH_W_HI;
                  PH_R_LO:  phase_in = PH_R_HI;
                  PH_RA_LO: phase_in = PH_RA_HI;
                  default:  phase_in = PH_WA_HI;
               endcase
               scl_in       = 1'b1;
               shift_reg_in = {shift_reg_ff[6:0], pop_item.sda_in};
               bit_count_in = bit_count_ff + 4'd1;
               if (phase_ff == PH_WA_LO) begin
                  ack_flag_in = !pop_item.sda_in;
               end
            end
            PH_W_HI: begin
               scl_in = 1'b0;
               if (bit_count_ff == BIT_COUNT_ZERO) begin
                  phase_in     = PH_WA_LO;
                  shift_reg_in = BYTE_ALL_ONES;
                  sda_in       = 1'b1;
                  bit_count_in = BIT_COUNT_ACK;
               end else begin
                  phase_in = PH_W_LO;
                  sda_in   = shift_reg_ff[7];
               end
            end
            PH_R_HI: begin
               scl_in = 1'b0;
               if (bit_count_ff == BIT_COUNT_ZERO) begin
                  phase_in     = PH_RA_LO;
                  rx_hold_in   = shift_reg_ff;
                  sda_in       = !ack_choice_ff;
                  bit_count_in = BIT_COUNT_ACK;
               end else begin
                  phase_in = PH_R_LO;
               end
            end
            PH_WA_HI, PH_RA_HI: begin
               phase_in = PH_IDLE;
               scl_in   = 1'b0;
               sda_in   = 1'b1;
               done     = 1'b1;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      result_in    = result_ff;
      if (step) begin
         rsp_valid_in       = 1'b1;
         result_in.scl_out  = scl_in;
         result_in.sda_out  = sda_in;
         result_in.busy_res = (phase_in != PH_IDLE);
         result_in.done_res = done;
         result_in.rx_byte  = rx_hold_in;
         result_in.ack_seen = ack_flag_in;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         bit_count_ff   <= BIT_COUNT_ZERO;
         shift_reg_ff   <= BYTE_ALL_ONES;
         divider_ff     <= '0;
         scl_ff         <= 1'b1;
         sda_ff         <= 1'b1;
         ack_choice_ff  <= 1'b0;
         ack_flag_ff    <= 1'b0;
         rx_hold_ff     <= '0;
         half_period_ff <= HALF_PERIOD_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (step) begin
            phase_ff      <= phase_in;
            bit_count_ff  <= bit_count_in;
            shift_reg_ff  <= shift_reg_in;
            divider_ff    <= divider_in;
            scl_ff        <= scl_in;
            sda_ff        <= sda_in;
            ack_choice_ff <= ack_choice_in;
            ack_flag_ff   <= ack_flag_in;
            rx_hold_ff    <= rx_hold_in;
         end
         if (csr_valid) begin
            half_period_ff <= csr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      result_ff <= result_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = result_ff;

endmodule

// File: hw/rtl/i2c_master_byte_controller_unit.sv
// I2C master byte controller: each accepted request is one system clock tick
// and yields exactly one response with the SCL/SDA drive levels, busy and done
// flags, the last received byte and the last write acknowledge. One tick is
// accepted every clock unless stalled; a response is offered once its request
// has passed the input register, four-entry queue and result register, and the
// queue lets either side stall on its own. Commands arriving while a command
// runs are dropped. Write the half period register only while no transfer is
// in flight; it takes effect from the next tick; csr_ready is always high.
module i2c_master_byte_controller_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // bits 7:0 tx_byte, bit 8 send_ack, bit 9 sda_in, 15:10 zero
   input  logic [8*i2cmb_pkg::REQ_BYTES-1:0]   req_tdata,
   // bits 2:0 cmd
   input  logic [2:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // bit 0 scl_out, 1 sda_out, 2 busy_res, 3 done_res, 11:4 rx_byte,
   // 12 ack_seen, 15:13 zero
   output logic [8*i2cmb_pkg::RSP_BYTES-1:0]   rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [i2cmb_pkg::DIVIDER_BITS-1:0]  csr_data
);
   import i2cmb_pkg::*;

   logic             push_valid, push_ready;
   queue_item_type   push_item;
   logic             pop_valid, pop_ready;
   queue_item_type   pop_item;
   queue_status_type queue_status;
   result_type       result;

   assign csr_ready = 1'b1;

   i2cmb_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_cmd      (req_tuser),
      .req_tx_byte  (req_tdata[7:0]),
      .req_send_ack (req_tdata[8]),
      .req_sda_in   (req_tdata[9]),
      .push_valid   (push_valid),
      .push_ready   (push_ready),
      .push_item    (push_item)
   );

   i2cmb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_item   (push_item),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_item  (pop_item),
      .status    (queue_status)
   );

   i2cmb_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid && csr_ready),
      .csr_data   (csr_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_result (result)
   );

   assign rsp_tdata = {3'b000, result.ack_seen, result.rx_byte, result.done_res,
                       result.busy_res, result.sda_out, result.scl_out};

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[3] |-> !rsp_tdata[2])
      else $error("done pulse reported while still busy");

   a_queue_bounded: assert property (@(posedge clock) disable iff (reset)
      queue_status.count <= (QUEUE_AW+1)'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_queue_flags: assert property (@(posedge clock) disable iff (reset)
      queue_status.full |-> queue_status.valid && !push_ready)
      else $error("full queue still accepting transfers");

endmodule

// File: tb/i2c_line_checker.sv
`timescale 1ns / 100ps
// Checker for the I2C master byte controller: predicts SCL/SDA levels and status per tick.
// Watches the request, response and half-period write channels; needs i2cmb_pkg only.
module i2c_line_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [8*i2cmb_pkg::REQ_BYTES-1:0]   req_tdata,
   input  logic [2:0]                          req_tuser,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [8*i2cmb_pkg::RSP_BYTES-1:0]   rsp_tdata,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [i2cmb_pkg::DIVIDER_BITS-1:0]  csr_data,
   output int unsigned                         fail_count,
   output int unsigned                         pending_count,
   output logic                                engine_idle
);
   import i2cmb_pkg::*;

   typedef enum logic [3:0] {
      LN_IDLE,
      LN_START_A,
      LN_START_B,
      LN_START_C,
      LN_STOP_A,
      LN_STOP_B,
      LN_STOP_C,
      LN_WR_LOW,
      LN_WR_HIGH,
      LN_WACK_LOW,
      LN_WACK_HIGH,
      LN_RD_LOW,
      LN_RD_HIGH,
      LN_RACK_LOW,
      LN_RACK_HIGH
   } bus_step_type;

   logic [DIVIDER_BITS-1:0] tick_span;
   bus_step_type            bus_step;
   logic [3:0]              bit_tally;
   logic [7:0]              shifter;
   logic [DIVIDER_BITS-1:0] span_count;
   logic                    scl_drive;
   logic                    sda_drive;
   logic                    read_ack;
   logic                    write_acked;
   logic [7:0]              last_rx;

   result_type              expected_levels[$];
   result_type              want;
   int unsigned             rsp_index;

   function automatic void shift_sda(input logic sda);
      shifter   = {shifter[6:0], sda};
      bit_tally = bit_tally + 4'd1;
   endfunction

   function automatic result_type next_bus_levels(input logic [2:0] code, input logic [7:0] tx,
                                                  input logic sack, input logic sda);
      result_type  levels;
      logic        done;
      int unsigned lim;
      done = 1'b0;
      lim  = (tick_span == '0) ? 1 : int'(tick_span);
      if (bus_step == LN_IDLE) begin
         span_count = '0;
         case (code)
            CMD_START: begin
               bus_step  = LN_START_A;
               scl_drive = 1'b1;
            end
            CMD_STOP: begin
               bus_step  = LN_STOP_A;
               sda_drive = 1'b0;
            end
            CMD_WRITE: begin
               bus_step  = LN_WR_LOW;
               shifter   = tx;
               bit_tally = BIT_COUNT_LOAD;
               scl_drive = 1'b0;
               sda_drive = tx[7];
            end
            CMD_READ: begin
               bus_step  = LN_RD_LOW;
               shifter   = BYTE_ALL_ONES;
               bit_tally = BIT_COUNT_LOAD;
               scl_drive = 1'b0;
               sda_drive = 1'b1;
               read_ack  = sack;
            end
            default: ;
         endcase
      end else if (int'(span_count) + 1 < lim) begin
         span_count = span_count + 1'b1;
      end else begin
         span_count = '0;
         case (bus_step)
            LN_START_A: begin
               bus_step  = LN_START_B;
               sda_drive = 1'b0;
            end
            LN_START_B: begin
               bus_step  = LN_START_C;
               scl_drive = 1'b0;
            end
            LN_START_C: begin
               bus_step  = LN_IDLE;
               sda_drive = 1'b1;
               shifter   = BYTE_ALL_ONES;
               done      = 1'b1;
            end
            LN_STOP_A: begin
               bus_step  = LN_STOP_B;
               scl_drive = 1'b1;
            end
            LN_STOP_B: begin
               bus_step  = LN_STOP_C;
               sda_drive = 1'b1;
            end
            LN_STOP_C: begin
               bus_step = LN_IDLE;
               done     = 1'b1;
            end
            LN_WR_LOW: begin
               bus_step  = LN_WR_HIGH;
               scl_drive = 1'b1;
               shift_sda(sda);
            end
            LN_WR_HIGH: begin
               scl_drive = 1'b0;
               if (bit_tally == BIT_COUNT_ZERO) begin
                  bus_step  = LN_WACK_LOW;
                  shifter   = BYTE_ALL_ONES;
                  sda_drive = 1'b1;
                  bit_tally = BIT_COUNT_ACK;
               end else begin
                  bus_step  = LN_WR_LOW;
                  sda_drive = shifter[7];
               end
            end
            LN_WACK_LOW: begin
               bus_step    = LN_WACK_HIGH;
               scl_drive   = 1'b1;
               shift_sda(sda);
               write_acked = !sda;
            end
            LN_WACK_HIGH, LN_RACK_HIGH: begin
               bus_step  = LN_IDLE;
               scl_drive = 1'b0;
               sda_drive = 1'b1;
               done      = 1'b1;
            end
            LN_RD_LOW: begin
               bus_step  = LN_RD_HIGH;
               scl_drive = 1'b1;
               shift_sda(sda);
            end
            LN_RD_HIGH: begin
               scl_drive = 1'b0;
               if (bit_tally == BIT_COUNT_ZERO) begin
                  bus_step  = LN_RACK_LOW;
                  last_rx   = shifter;
                  sda_drive = !read_ack;
                  bit_tally = BIT_COUNT_ACK;
               end else begin
                  bus_step = LN_RD_LOW;
               end
            end
            LN_RACK_LOW: begin
               bus_step  = LN_RACK_HIGH;
               scl_drive = 1'b1;
               shift_sda(sda);
            end
            default: bus_step = LN_IDLE;
         endcase
      end
      levels.scl_out  = scl_drive;
      levels.sda_out  = sda_drive;
      levels.busy_res = (bus_step != LN_IDLE);
      levels.done_res = done;
      levels.rx_byte  = last_rx;
      levels.ack_seen = write_acked;
      return levels;
   endfunction

   task automatic report_mismatch(input string field, input int got, input int expected_value);
      $display("mismatch on response %0d, %s: got %0h, expected %0h",
               rsp_index, field, got, expected_value);
      fail_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         tick_span   = HALF_PERIOD_RESET;
         bus_step    = LN_IDLE;
         bit_tally   = BIT_COUNT_ZERO;
         shifter     = BYTE_ALL_ONES;
         span_count  = '0;
         scl_drive   = 1'b1;
         sda_drive   = 1'b1;
         read_ack    = 1'b0;
         write_acked = 1'b0;
         last_rx     = '0;
         rsp_index   = 0;
         fail_count  = 0;
         expected_levels.delete();
      end else begin
         if (csr_valid && csr_ready)
            tick_span = csr_data;
         if (req_tvalid && req_tready)
            expected_levels.push_back(next_bus_levels(req_tuser, req_tdata[7:0],
                                                      req_tdata[8], req_tdata[9]));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_levels.size() == 0) begin
               report_mismatch("transfer with nothing expected", int'(rsp_tdata), 0);
            end else begin
               want = expected_levels.pop_front();
               if (rsp_tdata[0] !== want.scl_out)
                  report_mismatch("scl_out", rsp_tdata[0], want.scl_out);
               if (rsp_tdata[1] !== want.sda_out)
                  report_mismatch("sda_out", rsp_tdata[1], want.sda_out);
               if (rsp_tdata[2] !== want.busy_res)
                  report_mismatch("busy_res", rsp_tdata[2], want.busy_res);
               if (rsp_tdata[3] !== want.done_res)
                  report_mismatch("done_res", rsp_tdata[3], want.done_res);
               if (rsp_tdata[11:4] !== want.rx_byte)
                  report_mismatch("rx_byte", rsp_tdata[11:4], want.rx_byte);
               if (rsp_tdata[12] !== want.ack_seen)
                  report_mismatch("ack_seen", rsp_tdata[12], want.ack_seen);
            end
            rsp_index++;
         end
      end
      pending_count = expected_levels.size();
      engine_idle   = (bus_step == LN_IDLE);
   end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Top of the I2C master byte controller testbench: clock, reset, stimulus and verdict.
// Depends on i2cmb_pkg, the controller RTL and i2c_line_checker.
module tb_top;
   import i2cmb_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 100_000;
   localparam int unsigned ITEM_BUDGET   = 1050;
   localparam int unsigned SETTLE_CYCLES = 12;
   localparam logic [DIVIDER_BITS-1:0] SPAN_LONGEST = '1;

   logic                      clock;
   logic                      reset       = 1'b1;
   logic                      req_tvalid  = 1'b0;
   logic                      req_tready;
   logic [8*REQ_BYTES-1:0]    req_tdata   = '0;
   logic [2:0]                req_tuser   = CMD_NONE;
   logic                      rsp_tvalid;
   logic                      rsp_tready  = 1'b0;
   logic [8*RSP_BYTES-1:0]    rsp_tdata;
   logic                      csr_valid   = 1'b0;
   logic                      csr_ready;
   logic [DIVIDER_BITS-1:0]   csr_data    = '0;

   int unsigned               fail_count;
   int unsigned               pending_count;
   logic                      engine_idle;

   int unsigned               burst_left    = 0;
   bit                        steady        = 1'b0;
   logic [15:0]               stall_bits    = '0;
   logic [3:0]                stall_slot    = '0;
   int unsigned               cycle_count   = 0;
   int unsigned               items_sent    = 0;
   int unsigned               phase_goal;
   int unsigned               phase_no;
   int unsigned               noise_pct;
   int unsigned               byte_runs;
   logic [DIVIDER_BITS-1:0]   span;

   i2c_master_byte_controller_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   i2c_line_checker line_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .engine_idle   (engine_idle)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAILURE");
      $finish;
   end

   // reload the stall pattern each time the four-bit stall slot wraps, roughly one stall in four
   always @(negedge clock) begin
      stall_slot <= stall_slot + 4'd1;
      if (stall_slot == '0)
         stall_bits <= 16'($urandom) | 16'($urandom);
      rsp_tready <= steady || stall_bits[stall_slot];
   end

   task automatic send_tick(input logic [2:0] code, input logic [7:0] tx, input logic sack);
      int unsigned gap;
      if (!steady && burst_left == 0) begin
         gap = $urandom_range(1, 6);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
         burst_left = $urandom_range(1, 40);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= code;
      req_tdata  <= {6'd0, 1'($urandom_range(0, 1)), sack, tx};
      do @(posedge clock); while (!req_tready);
      items_sent++;
      @(negedge clock);
      if (burst_left > 0)
         burst_left--;
   endtask

   // tick along, sprinkling commands that a busy bus must ignore
   task automatic await_idle(input int unsigned noise);
      while (!engine_idle) begin
         if ($urandom_range(1, 100) <= noise)
            send_tick(3'($urandom), 8'($urandom), 1'($urandom));
         else
            send_tick(CMD_NONE, 8'($urandom), 1'($urandom));
      end
   endtask

   task automatic issue(input logic [2:0] code, input logic [7:0] tx, input logic sack,
                        input int unsigned noise);
      await_idle(noise);
      send_tick(code, tx, sack);
   endtask

   task automatic drain();
      await_idle(0);
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_count != 0) @(negedge clock);
   endtask

   // hold the sender, wait for every response, then write the half period
   task automatic write_now(input logic [DIVIDER_BITS-1:0] value);
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_count != 0) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic write_half_period(input logic [DIVIDER_BITS-1:0] value);
      await_idle(0);
      write_now(value);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset half period, cut short in the middle of a start
      steady = 1'b1;
      issue(CMD_START, 8'($urandom), 1'b0, 0);
      repeat (30) send_tick(CMD_NONE, 8'($urandom), 1'($urandom));
      steady = 1'b0;

      // zero half period behaves as one tick
      write_now('0);
      issue(CMD_START, 8'($urandom), 1'b0, 0);
      issue(CMD_WRITE, 8'h00, 1'b0, 0);
      issue(CMD_WRITE, 8'hFF, 1'b1, 0);
      issue(CMD_WRITE, 8'hA5, 1'b0, 0);
      issue(CMD_READ, 8'($urandom), 1'b1, 0);
      issue(CMD_READ, 8'($urandom), 1'b0, 0);
      issue(CMD_STOP, 8'($urandom), 1'b0, 0);
      issue(CMD_STOP, 8'($urandom), 1'b0, 0);
      issue(CMD_WRITE, 8'h80, 1'b0, 0);
      issue(CMD_READ, 8'($urandom), 1'b1, 0);
      for (int k = 1; k <= 3; k++)
         issue(3'(CMD_READ) + 3'(k), 8'($urandom), 1'($urandom), 0);
      issue(CMD_START, 8'($urandom), 1'b0, 0);
      send_tick(CMD_WRITE, 8'h3C, 1'b0);
      send_tick(CMD_STOP, 8'($urandom), 1'b0);
      issue(CMD_READ, 8'($urandom), 1'b0, 0);
      send_tick(CMD_START, 8'($urandom), 1'b1);
      issue(CMD_STOP, 8'($urandom), 1'b0, 0);

      // longest half period, then shorten it in the middle of a start
      write_half_period(SPAN_LONGEST);
      steady = 1'b1;
      issue(CMD_START, 8'($urandom), 1'b0, 0);
      repeat (40) send_tick(CMD_NONE, 8'($urandom), 1'($urandom));
      steady = 1'b0;
      write_now(DIVIDER_BITS'(1));

      phase_no = 0;
      while (items_sent < ITEM_BUDGET) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: span = DIVIDER_BITS'($urandom_range(1, 2));
            6, 7:             span = DIVIDER_BITS'($urandom_range(3, 4));
            8:                span = DIVIDER_BITS'($urandom_range(5, 8));
            default:          span = DIVIDER_BITS'(1);
         endcase
         if (phase_no == 0)
            span = DIVIDER_BITS'(1);
         write_half_period(span);
         steady     = ($urandom_range(0, 3) == 0);
         noise_pct  = $urandom_range(0, 30);
         phase_goal = items_sent + $urandom_range(100, 250);
         while (items_sent < phase_goal && items_sent < ITEM_BUDGET) begin
            if ($urandom_range(1, 100) <= 85) begin
               issue(CMD_START, 8'($urandom), 1'($urandom), noise_pct);
               byte_runs = $urandom_range(1, 3);
               repeat (byte_runs) begin
                  if (items_sent < ITEM_BUDGET) begin
                     if ($urandom_range(0, 1))
                        issue(CMD_WRITE, 8'($urandom), 1'($urandom), noise_pct);
                     else
                        issue(CMD_READ, 8'($urandom), 1'($urandom), noise_pct);
                  end
               end
               issue(CMD_STOP, 8'($urandom), 1'($urandom), noise_pct);
            end else begin
               issue(3'($urandom), 8'($urandom), 1'($urandom), noise_pct);
            end
            // hold off until every response is back
            if ($urandom_range(1, 20) == 1)
               drain();
         end
         phase_no++;
      end

      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
